FILE: rtl/core/point_rigid_transform_core_defines.svh
// assertion macros for the point rigid transform core
// used by point_rigid_transform_core; expects clk and rst_n in scope
`ifndef POINT_RIGID_TRANSFORM_CORE_DEFINES_SVH
`define POINT_RIGID_TRANSFORM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define PRT_ASSERT(lbl, prop, msg)
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/prt_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and arithmetic helpers of the point rigid transform core
// no dependencies
package prt_pkg;

  localparam int COORD_W   = 32;
  localparam int Q_W       = 32;
  localparam int ENTRY_W   = 32;
  localparam int TWICE_W   = 35;
  localparam int SUMQ_W    = 37;
  localparam int OFF_W     = 22;
  localparam int OFFP_W    = 54;
  localparam int PROD_W    = 63;
  localparam int ACC_W     = 64;
  localparam int ROT_W     = 34;
  localparam int TRANS_W   = 34;
  localparam int MAP_W     = 36;
  localparam int CFG_IDX_W = 3;
  localparam int BUSY_W    = 3;

  localparam logic [BUSY_W-1:0] ROT_LAT = BUSY_W'(4);

  localparam int OFFSET_X_DEF = 0;
  localparam int OFFSET_Y_DEF = 0;
  localparam int OFFSET_Z_DEF = 0;

  localparam logic signed [Q_W-1:0] QW_RESET = 32'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QX = 3'd0,
    REG_QY = 3'd1,
    REG_QZ = 3'd2,
    REG_QW = 3'd3,
    REG_PX = 3'd4,
    REG_PY = 3'd5,
    REG_PZ = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [Q_W-1:0]     qx;
    logic signed [Q_W-1:0]     qy;
    logic signed [Q_W-1:0]     qz;
    logic signed [Q_W-1:0]     qw;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } prt_cfg_t;

  typedef struct packed {
    logic [8:0][ENTRY_W-1:0] m;
    logic [2:0][TRANS_W-1:0] t;
  } prt_xform_t;

  function automatic logic signed [ENTRY_W-1:0] clamp_entry(input logic signed [SUMQ_W-1:0] v);
    logic signed [ENTRY_W-1:0] r;
    if (v > 37'sd1073741824) r = 32'sd1073741824;
    else if (v < -37'sd1073741824) r = -32'sd1073741824;
    else r = v[ENTRY_W-1:0];
    return r;
  endfunction

  // round half up from Q.46 to Q16.16
  function automatic logic signed [ROT_W-1:0] round_q30(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    r = (s + 64'sd536870912) >>> 30;
    return r[ROT_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [MAP_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/prt_in_if.sv
`timescale 1ns / 1ps
// input point channel: valid/ready with one sensor-frame point per beat
// depends on prt_pkg
interface prt_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [prt_pkg::COORD_W-1:0] in_x;
  logic signed [prt_pkg::COORD_W-1:0] in_y;
  logic signed [prt_pkg::COORD_W-1:0] in_z;
  logic                              in_finite;

  modport source (output valid, in_x, in_y, in_z, in_finite, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_finite, output ready);
endinterface

FILE: rtl/core/prt_out_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready with one map-frame point per beat
// depends on prt_pkg
interface prt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [prt_pkg::COORD_W-1:0] map_x;
  logic signed [prt_pkg::COORD_W-1:0] map_y;
  logic signed [prt_pkg::COORD_W-1:0] map_z;
  logic                              kept;

  modport source (output valid, map_x, map_y, map_z, kept, input ready);
  modport sink (input valid, map_x, map_y, map_z, kept, output ready);
endinterface

FILE: rtl/core/prt_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel: register index and write data per beat
// depends on prt_pkg
interface prt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [prt_pkg::CFG_IDX_W-1:0]     index;
  logic [prt_pkg::COORD_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/prt_rotation.sv
`timescale 1ns / 1ps
// rotation matrix from the quaternion and translation pose + R * offset
// four register stages; depends on prt_pkg
module prt_rotation #(
  parameter int OFFSET_X = prt_pkg::OFFSET_X_DEF,
  parameter int OFFSET_Y = prt_pkg::OFFSET_Y_DEF,
  parameter int OFFSET_Z = prt_pkg::OFFSET_Z_DEF
) (
  input  logic                clk,
  input  prt_pkg::prt_cfg_t   cfg,
  output prt_pkg::prt_xform_t xform
);

  localparam logic signed [prt_pkg::OFF_W-1:0] OFF_V [3] = '{
    prt_pkg::OFF_W'(OFFSET_X), prt_pkg::OFF_W'(OFFSET_Y), prt_pkg::OFF_W'(OFFSET_Z)
  };
  localparam logic signed [prt_pkg::SUMQ_W-1:0] ONE_Q = 37'sd1073741824;

  function automatic logic signed [prt_pkg::TWICE_W-1:0] twice(
    input logic signed [prt_pkg::Q_W-1:0] a,
    input logic signed [prt_pkg::Q_W-1:0] b
  );
    logic signed [prt_pkg::ACC_W-1:0] p;
    p = 64'(a) * 64'(b);
    p = p >>> 29;
    return p[prt_pkg::TWICE_W-1:0];
  endfunction

  logic signed [prt_pkg::TWICE_W-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [prt_pkg::SUMQ_W-1:0]  sum_nxt [9];
  logic signed [prt_pkg::ENTRY_W-1:0] ent_r [9];
  logic signed [prt_pkg::OFFP_W-1:0]  offp_r [9];
  logic signed [prt_pkg::TRANS_W-1:0] t_r [3];
  logic signed [prt_pkg::COORD_W-1:0] pose [3];

  // stage a: doubled quaternion products
  always_ff @(posedge clk) begin
    xx_r <= twice(cfg.qx, cfg.qx);
    yy_r <= twice(cfg.qy, cfg.qy);
    zz_r <= twice(cfg.qz, cfg.qz);
    xy_r <= twice(cfg.qx, cfg.qy);
    xz_r <= twice(cfg.qx, cfg.qz);
    yz_r <= twice(cfg.qy, cfg.qz);
    wx_r <= twice(cfg.qw, cfg.qx);
    wy_r <= twice(cfg.qw, cfg.qy);
    wz_r <= twice(cfg.qw, cfg.qz);
  end

  // stage b: matrix entries
  always_comb begin
    sum_nxt[0] = ONE_Q - (37'(yy_r) + 37'(zz_r));
    sum_nxt[1] = 37'(xy_r) - 37'(wz_r);
    sum_nxt[2] = 37'(xz_r) + 37'(wy_r);
    sum_nxt[3] = 37'(xy_r) + 37'(wz_r);
    sum_nxt[4] = ONE_Q - (37'(xx_r) + 37'(zz_r));
    sum_nxt[5] = 37'(yz_r) - 37'(wx_r);
    sum_nxt[6] = 37'(xz_r) - 37'(wy_r);
    sum_nxt[7] = 37'(yz_r) + 37'(wx_r);
    sum_nxt[8] = ONE_Q - (37'(xx_r) + 37'(yy_r));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      ent_r[i] <= prt_pkg::clamp_entry(sum_nxt[i]);
    end
  end

  // stage c: entries times sensor offset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      offp_r[i] <= 54'(ent_r[i]) * 54'(OFF_V[i % 3]);
    end
  end

  assign pose[0] = cfg.px;
  assign pose[1] = cfg.py;
  assign pose[2] = cfg.pz;

  // stage d: translation kept wide
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= prt_pkg::round_q30(64'(offp_r[3*i]) + 64'(offp_r[3*i+1]) + 64'(offp_r[3*i+2]))
                + 34'(pose[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      xform.m[i] = ent_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      xform.t[i] = t_r[i];
    end
  end

endmodule

FILE: rtl/core/point_rigid_transform_core.sv
`timescale 1ns / 1ps
// point rigid transform core: sensor-frame points mapped into the map frame
// depends on prt_pkg, prt_in_if, prt_out_if, prt_cfg_if, prt_rotation and the defines header
//
// channels: in_pt takes one Q16.16 point and a finite flag per beat, out_pt gives
// the mapped, saturated point and the kept flag, cfg_wr writes the quaternion (Q2.30)
// and the vehicle position (Q16.16) by register index; unknown indexes are ignored.
// throughput: one point per cycle while out_pt is ready and no rebuild runs, set by
// the three-stage multiply-add pipeline (nine products, row sums with rounding,
// translation add and saturation). a point goes through the stage 1, 2 and 3
// registers to out_pt; a stalled receiver holds the output beat and empty stages
// still fill, so in_pt stays ready until all three stages hold a point.
// reset: synchronous, active low; quaternion set to identity, position to zero.
// the matrix and translation are rebuilt while busy_r counts down after reset and
// each configuration beat; in_pt is not ready meanwhile. cfg_wr is always ready; the
// user must write it only while no point is in flight; the block does not check.
`include "point_rigid_transform_core_defines.svh"
module point_rigid_transform_core #(
  parameter int OFFSET_X = prt_pkg::OFFSET_X_DEF,
  parameter int OFFSET_Y = prt_pkg::OFFSET_Y_DEF,
  parameter int OFFSET_Z = prt_pkg::OFFSET_Z_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prt_in_if.sink     in_pt,
  prt_out_if.source  out_pt,
  prt_cfg_if.sink    cfg_wr
);

  prt_pkg::prt_cfg_t   cfg_r;
  prt_pkg::prt_xform_t xform;
  logic [prt_pkg::BUSY_W-1:0] busy_r;

  logic in_fire, cfg_fire;
  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;
  logic fin1_r, fin2_r, kept_r;

  logic signed [prt_pkg::PROD_W-1:0]  prod1_r [9];
  logic signed [prt_pkg::ROT_W-1:0]   rot2_r [3];
  logic signed [prt_pkg::COORD_W-1:0] map_r [3];
  logic signed [prt_pkg::COORD_W-1:0] pt [3];

  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid && cfg_wr.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qx <= '0;
      cfg_r.qy <= '0;
      cfg_r.qz <= '0;
      cfg_r.qw <= prt_pkg::QW_RESET;
      cfg_r.px <= '0;
      cfg_r.py <= '0;
      cfg_r.pz <= '0;
    end else if (cfg_fire) begin
      case (prt_pkg::cfg_idx_t'(cfg_wr.index))
        prt_pkg::REG_QX: cfg_r.qx <= cfg_wr.data;
        prt_pkg::REG_QY: cfg_r.qy <= cfg_wr.data;
        prt_pkg::REG_QZ: cfg_r.qz <= cfg_wr.data;
        prt_pkg::REG_QW: cfg_r.qw <= cfg_wr.data;
        prt_pkg::REG_PX: cfg_r.px <= cfg_wr.data;
        prt_pkg::REG_PY: cfg_r.py <= cfg_wr.data;
        prt_pkg::REG_PZ: cfg_r.pz <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // rebuild window for matrix and translation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= prt_pkg::ROT_LAT;
    end else if (cfg_fire) begin
      busy_r <= prt_pkg::ROT_LAT;
    end else if (busy_r != '0) begin
      busy_r <= busy_r - 1'b1;
    end
  end

  prt_rotation #(
    .OFFSET_X(OFFSET_X),
    .OFFSET_Y(OFFSET_Y),
    .OFFSET_Z(OFFSET_Z)
  ) u_rot (
    .clk  (clk),
    .cfg  (cfg_r),
    .xform(xform)
  );

  // per-stage enables let bubbles fill under a stalled output
  assign en3 = !v3_r || out_pt.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_pt.ready = en1 && (busy_r == '0);
  assign in_fire     = in_pt.valid && in_pt.ready;

  assign pt[0] = in_pt.in_x;
  assign pt[1] = in_pt.in_y;
  assign pt[2] = in_pt.in_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_fire;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: matrix times point
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fin1_r <= in_pt.in_finite;
      for (int i = 0; i < 9; i++) begin
        prod1_r[i] <= 63'($signed(xform.m[i])) * 63'(pt[i % 3]);
      end
    end
  end

  // stage 2: row sums rounded to Q16.16
  always_ff @(posedge clk) begin
    if (v1_r && en2) begin
      fin2_r <= fin1_r;
      for (int i = 0; i < 3; i++) begin
        rot2_r[i] <= prt_pkg::round_q30(64'(prod1_r[3*i]) + 64'(prod1_r[3*i+1])
                                        + 64'(prod1_r[3*i+2]));
      end
    end
  end

  // stage 3: translation, saturation and drop
  always_ff @(posedge clk) begin
    if (v2_r && en3) begin
      kept_r <= fin2_r;
      for (int i = 0; i < 3; i++) begin
        map_r[i] <= fin2_r ? prt_pkg::sat32(36'(rot2_r[i]) + 36'($signed(xform.t[i]))) : '0;
      end
    end
  end

  assign out_pt.valid = v3_r;
  assign out_pt.map_x = map_r[0];
  assign out_pt.map_y = map_r[1];
  assign out_pt.map_z = map_r[2];
  assign out_pt.kept  = kept_r;

  `PRT_ASSERT(a_no_accept_busy, in_fire |-> (busy_r == '0), "point taken during matrix rebuild")
  `PRT_ASSERT_NEXT(a_cfg_blocks_in, cfg_fire, !in_pt.ready, "in ready right after config beat")
  `PRT_ASSERT_NEXT(a_s2_hold, v2_r && !en3, v2_r, "stage two point lost under stall")
  `PRT_ASSERT(a_drop_zero, (v3_r && !kept_r) |-> (map_r[0] == '0 && map_r[1] == '0 && map_r[2] == '0), "dropped point not zero")

endmodule

FILE: verif/tb_point_rigid_transform_core.sv
`timescale 1ns / 1ps
// self-checking bench for point_rigid_transform_core: points in, map-frame points out
// predicts each beat from its own copy of quaternion and pose; needs prt_pkg and the channel ifs
module tb_point_rigid_transform_core;

  localparam int OFFSET_X = prt_pkg::OFFSET_X_DEF;
  localparam int OFFSET_Y = prt_pkg::OFFSET_Y_DEF;
  localparam int OFFSET_Z = prt_pkg::OFFSET_Z_DEF;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam logic [prt_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sd1073741824;
  localparam logic signed [31:0] Q_HALF_SQRT2 = 32'sd759250125;
  localparam int CYCLE_LIMIT = 400000;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               kept;
  } map_pt_t;

  logic clk;
  logic rst_n;

  prt_in_if  in_pt();
  prt_out_if out_pt();
  prt_cfg_if cfg_wr();

  point_rigid_transform_core #(
    .OFFSET_X(OFFSET_X),
    .OFFSET_Y(OFFSET_Y),
    .OFFSET_Z(OFFSET_Z)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_pt(in_pt),
    .out_pt(out_pt),
    .cfg_wr(cfg_wr)
  );

  logic signed [31:0] quat_reg [4];
  logic signed [31:0] pose_reg [3];
  // expected beats, written by the sender and read by the checker
  map_pt_t exp_mem [EXP_DEPTH];
  logic [3:0] exp_wr_ptr = '0;
  logic [3:0] exp_rd_ptr = '0;
  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  int hold_seq = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint twice_q(input longint a, input longint b);
    return (a * b) >>> 29;
  endfunction

  function automatic longint clamp_q(input longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic longint round_row(input longint a, b, c, u, v, w);
    return (a * u + b * v + c * w + HALF_Q30) >>> 30;
  endfunction

  function automatic logic signed [31:0] sat_coord(input longint v);
    if (v > 64'sd2147483647) return COORD_MAX;
    if (v < -64'sd2147483648) return COORD_MIN;
    return v[31:0];
  endfunction

  function automatic map_pt_t map_point(input logic signed [31:0] sx, sy, sz, input logic fin);
    longint qx, qy, qz, qw;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint r [9];
    longint pt [3];
    longint mapped [3];
    map_pt_t res;
    res = '0;
    if (!fin) return res;
    qx = quat_reg[0];
    qy = quat_reg[1];
    qz = quat_reg[2];
    qw = quat_reg[3];
    xx = twice_q(qx, qx);
    yy = twice_q(qy, qy);
    zz = twice_q(qz, qz);
    xy = twice_q(qx, qy);
    xz = twice_q(qx, qz);
    yz = twice_q(qy, qz);
    wx = twice_q(qw, qx);
    wy = twice_q(qw, qy);
    wz = twice_q(qw, qz);
    r[0] = clamp_q(ONE_Q30 - (yy + zz));
    r[1] = clamp_q(xy - wz);
    r[2] = clamp_q(xz + wy);
    r[3] = clamp_q(xy + wz);
    r[4] = clamp_q(ONE_Q30 - (xx + zz));
    r[5] = clamp_q(yz - wx);
    r[6] = clamp_q(xz - wy);
    r[7] = clamp_q(yz + wx);
    r[8] = clamp_q(ONE_Q30 - (xx + yy));
    pt[0] = sx;
    pt[1] = sy;
    pt[2] = sz;
    for (int i = 0; i < 3; i++) begin
      mapped[i] = round_row(r[3*i], r[3*i+1], r[3*i+2], pt[0], pt[1], pt[2]) + pose_reg[i]
                + round_row(r[3*i], r[3*i+1], r[3*i+2], OFFSET_X, OFFSET_Y, OFFSET_Z);
    end
    res.x = sat_coord(mapped[0]);
    res.y = sat_coord(mapped[1]);
    res.z = sat_coord(mapped[2]);
    res.kept = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("mismatch on %s: expected %0d got %0d (cycle %0d)", field, want, got, cycle_count);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    map_pt_t want;
    if (rst_n && out_pt.valid && out_pt.ready) begin
      if (exp_wr_ptr == exp_rd_ptr) begin
        report_mismatch("unexpected beat", 0, 1);
      end else begin
        want = exp_mem[exp_rd_ptr];
        exp_rd_ptr = exp_rd_ptr + 4'd1;
        if (out_pt.map_x !== want.x) report_mismatch("map_x", want.x, out_pt.map_x);
        if (out_pt.map_y !== want.y) report_mismatch("map_y", want.y, out_pt.map_y);
        if (out_pt.map_z !== want.z) report_mismatch("map_z", want.z, out_pt.map_z);
        if (out_pt.kept !== want.kept) report_mismatch("kept", want.kept, out_pt.kept);
      end
    end
  end

  // receiver: stall mode redrawn at random when mode_left runs out, long hold-off on request
  initial begin
    int stall_mode;
    int mode_left;
    int hold_left;
    int tick;
    int seen_seq;
    stall_mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    seen_seq = 0;
    out_pt.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = hold_cycles;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = 48;
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_pt.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_pt.ready <= 1'b1;
          1: out_pt.ready <= 1'($urandom_range(0, 1));
          2: out_pt.ready <= ($urandom_range(0, 3) != 0);
          default: out_pt.ready <= ((tick % 7) >= 3);
        endcase
      end
    end
  end

  task automatic send_point(input logic signed [31:0] sx, sy, sz, input logic fin);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_pt.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_pt.valid <= 1'b1;
    in_pt.in_x <= sx;
    in_pt.in_y <= sy;
    in_pt.in_z <= sz;
    in_pt.in_finite <= fin;
    do @(posedge clk); while (!in_pt.ready);
    exp_mem[exp_wr_ptr] = map_point(sx, sy, sz, fin);
    exp_wr_ptr = exp_wr_ptr + 4'd1;
  endtask

  task automatic wait_idle();
    in_pt.valid <= 1'b0;
    while (exp_wr_ptr != exp_rd_ptr) @(posedge clk);
  endtask

  // leaves valid high; close a run of writes with end_writes
  task automatic write_reg(input logic [prt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    case (idx)
      prt_pkg::REG_QX: quat_reg[0] = data;
      prt_pkg::REG_QY: quat_reg[1] = data;
      prt_pkg::REG_QZ: quat_reg[2] = data;
      prt_pkg::REG_QW: quat_reg[3] = data;
      prt_pkg::REG_PX: pose_reg[0] = data;
      prt_pkg::REG_PY: pose_reg[1] = data;
      prt_pkg::REG_PZ: pose_reg[2] = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic set_pose(input logic signed [31:0] qx, qy, qz, qw, px, py, pz);
    write_reg(prt_pkg::REG_QX, qx);
    write_reg(prt_pkg::REG_QY, qy);
    write_reg(prt_pkg::REG_QZ, qz);
    write_reg(prt_pkg::REG_QW, qw);
    write_reg(prt_pkg::REG_PX, px);
    write_reg(prt_pkg::REG_PY, py);
    write_reg(prt_pkg::REG_PZ, pz);
    end_writes();
  endtask

  function automatic logic signed [31:0] rand_q();
    return 32'(longint'($urandom_range(0, 32'h80000000)) - ONE_Q30);
  endfunction

  task automatic set_random_pose(input bit unit_len, input bit pose_extreme);
    real c [4];
    real norm;
    logic signed [31:0] q [4];
    norm = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = $itor($urandom_range(0, 2000)) - 1000.0;
      norm += c[i] * c[i];
    end
    if (norm < 1.0) begin
      c[3] = 1.0;
      norm = 1.0;
    end
    norm = $sqrt(norm);
    for (int i = 0; i < 4; i++) begin
      if (unit_len) q[i] = $rtoi(c[i] / norm * 1073741823.0);
      else q[i] = rand_q();
    end
    if (pose_extreme)
      set_pose(q[0], q[1], q[2], q[3], COORD_MAX, COORD_MIN, $urandom);
    else
      set_pose(q[0], q[1], q[2], q[3], $urandom, $urandom, $urandom);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 32'(longint'($urandom_range(0, 32'h200000)) - 64'sd1048576);
      6, 7: return $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return 32'(longint'($urandom_range(0, 32'h20000000)) - 64'sd268435456);
    endcase
  endfunction

  task automatic send_random_point();
    send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 9) != 0);
  endtask

  task automatic test_identity_extremes();
    send_point(32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_point(COORD_MAX, COORD_MIN, 32'sd65536, 1'b1);
    send_point(COORD_MIN, COORD_MAX, -32'sd65536, 1'b1);
    send_point(-32'sd1, -32'sd1, -32'sd1, 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    // dropped point with live coordinates
    send_point(32'sd123456, -32'sd98765, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, -32'sd1, 1'b0);
    wait_idle();
  endtask

  task automatic test_fixed_rotations();
    // half turn about z
    set_pose(32'sd0, 32'sd0, Q_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_point(32'sd65536, 32'sd131072, 32'sd196608, 1'b1);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    send_point(-32'sd1, 32'sd1, 32'sd0, 1'b1);
    wait_idle();
    // quarter turn about x, position at the top to force saturation
    set_pose(Q_HALF_SQRT2, 32'sd0, 32'sd0, Q_HALF_SQRT2, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(32'sd65536, 32'sd65536, 32'sd65536, 1'b1);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
    wait_idle();
    // non-unit quaternion, entries clamp
    set_pose(Q_ONE, Q_ONE, Q_ONE, Q_ONE, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, 32'sd65536, -32'sd65536, 1'b1);
    wait_idle();
    set_pose(-Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, COORD_MAX, 32'sd0, COORD_MIN);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_point(32'sd1, -32'sd1, 32'sd1, 1'b1);
    wait_idle();
  endtask

  task automatic test_unused_index();
    write_reg(REG_NONE, $urandom);
    end_writes();
    send_point(32'sd65536, -32'sd65536, 32'sd12345, 1'b1);
    send_point(COORD_MAX, 32'sd0, COORD_MIN, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: set_random_pose(1'b1, 1'b0);
        1: set_random_pose(1'b1, phase == 4);
        default: set_random_pose(1'b0, 1'b0);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      repeat (110) send_random_point();
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    set_random_pose(1'b1, 1'b0);
    gaps_on = 1'b0;
    hold_cycles = 200;
    hold_seq++;
    repeat (40) send_random_point();
    wait_idle();
    gaps_on = 1'b1;
    burst_left = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_pt.valid = 1'b0;
    in_pt.in_x = '0;
    in_pt.in_y = '0;
    in_pt.in_z = '0;
    in_pt.in_finite = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    quat_reg[0] = 32'sd0;
    quat_reg[1] = 32'sd0;
    quat_reg[2] = 32'sd0;
    quat_reg[3] = prt_pkg::QW_RESET;
    pose_reg[0] = 32'sd0;
    pose_reg[1] = 32'sd0;
    pose_reg[2] = 32'sd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_extremes();
    test_fixed_rotations();
    test_unused_index();
    test_random_traffic();
    test_back_pressure();
    set_pose(32'sd0, 32'sd0, 32'sd0, prt_pkg::QW_RESET, 32'sd0, 32'sd0, 32'sd0);
    repeat (40) send_random_point();
    wait_idle();
    repeat (16) @(posedge clk);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
